// ===== rtl/swfa_pkg.sv =====
// Package for the seasonal window-average fit block.
// Holds sizes, register indexes, the sequencer state type and the divider result type.
// No dependencies.
package swfa_pkg;

    localparam int MAX_PERIOD   = 64;
    localparam int MAX_WINDOW   = 8;
    localparam int SAMPLE_BITS  = 32;
    localparam int RING_DEPTH   = MAX_PERIOD * MAX_WINDOW;
    localparam int ADDR_BITS    = $clog2(RING_DEPTH);
    localparam int BACK_BITS    = $clog2(RING_DEPTH + 1);
    localparam int PERIOD_BITS  = 7;
    localparam int WINDOW_BITS  = 4;
    localparam int PHASE_BITS   = 6;
    localparam int KBITS        = $clog2(MAX_WINDOW + 1);
    localparam int SUM_BITS     = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_BITS     = PERIOD_BITS;
    localparam int DIV_CNT_BITS = $clog2(SUM_BITS + 1);

    localparam logic [CFG_IDX_BITS-1:0] REG_SEASON_LENGTH = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_LENGTH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DIVGO,
        ST_DIV
    } seq_state_t;

    typedef struct packed {
        logic                          done;
        logic                          busy;
        logic signed [SAMPLE_BITS-1:0] quot;
    } div_res_t;

endpackage

// ===== rtl/swfa_hist.sv =====
// History ring of past samples: one write port, one read port with registered data.
// Depends on swfa_pkg.
module swfa_hist
(
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [swfa_pkg::ADDR_BITS-1:0]        wr_addr,
    input  logic [swfa_pkg::SAMPLE_BITS-1:0]      wr_data,
    input  logic                                  rd_en,
    input  logic [swfa_pkg::ADDR_BITS-1:0]        rd_addr,
    output logic [swfa_pkg::SAMPLE_BITS-1:0]      rd_data
);

    logic [swfa_pkg::SAMPLE_BITS-1:0] mem [swfa_pkg::RING_DEPTH];
    logic [swfa_pkg::SAMPLE_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/swfa_div.sv =====
// Restoring radix-2 divider: signed sum by a small unsigned count, truncating toward zero.
// One quotient bit per cycle. Depends on swfa_pkg.
module swfa_div
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [swfa_pkg::SUM_BITS-1:0]  dividend,
    input  logic [swfa_pkg::KBITS-1:0]            divisor,
    output swfa_pkg::div_res_t                    res
);

    logic                                busy_reg, busy_next;
    logic                                done_reg, done_next;
    logic [swfa_pkg::DIV_CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                                neg_reg, neg_next;
    logic [swfa_pkg::SUM_BITS-1:0]       quo_reg, quo_next;
    logic [swfa_pkg::KBITS-1:0]          rem_reg, rem_next;
    logic [swfa_pkg::KBITS-1:0]          dvs_reg, dvs_next;
    logic [swfa_pkg::KBITS:0]            trial;
    logic [swfa_pkg::SUM_BITS-1:0]       signed_quo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, quo_reg[swfa_pkg::SUM_BITS-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = swfa_pkg::DIV_CNT_BITS'(swfa_pkg::SUM_BITS);
            neg_next  = dividend[swfa_pkg::SUM_BITS-1];
            quo_next  = dividend[swfa_pkg::SUM_BITS-1] ? 
                        swfa_pkg::SUM_BITS'(-dividend) : dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = swfa_pkg::KBITS'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[swfa_pkg::SUM_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[swfa_pkg::KBITS-1:0];
                quo_next = {quo_reg[swfa_pkg::SUM_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == swfa_pkg::DIV_CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign signed_quo = neg_reg ? -quo_reg : quo_reg;
    assign res.done   = done_reg;
    assign res.busy   = busy_reg;
    assign res.quot   = signed_quo[swfa_pkg::SAMPLE_BITS-1:0];

endmodule

// ===== rtl/seasonal_window_average_fit.sv =====
// Top level of the seasonal window-average fit: sequencer, accumulator and result register.
// Depends on swfa_pkg, swfa_hist and swfa_div.
//
// Usage:
//   Input channel: sample and series_start with in_valid; the block raises in_stall
//   while it works on a word. A word is taken when in_valid is high and in_stall low.
//   Output channel: fitted, residual and from_history with out_valid; the receiver
//   holds out_stall high to keep the word; the block then waits before finishing the
//   next word.
//   Configuration: cfg_we with cfg_index and cfg_data; any write restarts the series.
//   Sequencing: a first-season word goes straight to the finish step. Later, with
//   k = min(seasons completed, window) the word makes k history reads on the single
//   ring read port, launches the divider, runs the bit-serial divider (35 quotient
//   bits, then done), then goes to the finish step, which loads the result. The next
//   word is taken only after the last one is finished.
//   The result register lets a new word enter while the last result waits.
//   Reset: clears position, phase, season count and control; configuration returns
//   to a period of 1 and a window of 1. The history ring is not cleared.
module seasonal_window_average_fit
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [swfa_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                                    series_start,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [swfa_pkg::SAMPLE_BITS-1:0] fitted,
    output logic signed [swfa_pkg::SAMPLE_BITS-1:0] residual,
    output logic                                    from_history,
    input  logic                                    cfg_we,
    input  logic [swfa_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [swfa_pkg::CFG_BITS-1:0]           cfg_data
);

    localparam int SB = swfa_pkg::SAMPLE_BITS;

    swfa_pkg::seq_state_t state_reg, state_next;

    logic [swfa_pkg::PERIOD_BITS-1:0] period_reg, period_next;
    logic [swfa_pkg::WINDOW_BITS-1:0] window_reg, window_next;
    logic [swfa_pkg::ADDR_BITS-1:0]   wpos_reg, wpos_next;
    logic [swfa_pkg::PHASE_BITS-1:0]  phase_reg, phase_next;
    logic [swfa_pkg::KBITS-1:0]       seasons_reg, seasons_next;
    logic [swfa_pkg::KBITS-1:0]       k_reg, k_next;
    logic [swfa_pkg::KBITS-1:0]       rcnt_reg, rcnt_next;
    logic [swfa_pkg::BACK_BITS-1:0]   back_reg, back_next;
    logic signed [swfa_pkg::SUM_BITS-1:0] sum_reg, sum_next;
    logic signed [SB-1:0]             x_reg, x_next;
    logic signed [SB-1:0]             fit_reg, fit_next;
    logic                             hist_reg, hist_next;
    logic                             fin_reg, fin_next;
    logic                             out_valid_reg, out_valid_next;
    logic signed [SB-1:0]             fitted_reg, fitted_next;
    logic signed [SB-1:0]             resid_reg, resid_next;
    logic                             ohist_reg, ohist_next;

    logic [swfa_pkg::PERIOD_BITS-1:0] p_eff;
    logic [swfa_pkg::KBITS-1:0]       w_eff;
    logic [swfa_pkg::KBITS-1:0]       seasons_cur;
    logic [swfa_pkg::PERIOD_BITS-1:0] phase_inc;
    logic signed [SB:0]               diff;
    logic signed [SB-1:0]             resid_sat;
    logic                             in_take;
    logic                             out_free;
    logic                             rd_en;
    logic [swfa_pkg::ADDR_BITS-1:0]   rd_addr;
    logic [SB-1:0]                    rd_data;
    logic                             wr_en;
    logic                             div_start;
    swfa_pkg::div_res_t               div_res;

    swfa_hist u_hist
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wpos_reg),
        .wr_data (x_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    swfa_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (k_reg),
        .res      (div_res)
    );

    always_comb
    begin
        if (period_reg == '0)
        begin
            p_eff = swfa_pkg::PERIOD_BITS'(1);
        end
        else if (period_reg > swfa_pkg::PERIOD_BITS'(swfa_pkg::MAX_PERIOD))
        begin
            p_eff = swfa_pkg::PERIOD_BITS'(swfa_pkg::MAX_PERIOD);
        end
        else
        begin
            p_eff = period_reg;
        end
        if (window_reg == '0)
        begin
            w_eff = swfa_pkg::KBITS'(1);
        end
        else if (window_reg > swfa_pkg::WINDOW_BITS'(swfa_pkg::MAX_WINDOW))
        begin
            w_eff = swfa_pkg::KBITS'(swfa_pkg::MAX_WINDOW);
        end
        else
        begin
            w_eff = window_reg[swfa_pkg::KBITS-1:0];
        end
    end

    assign in_stall  = (state_reg != swfa_pkg::ST_IDLE) || fin_reg;
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign rd_addr   = wpos_reg - back_reg[swfa_pkg::ADDR_BITS-1:0];
    assign phase_inc = {1'b0, phase_reg} + 1'b1;
    assign diff      = {x_reg[SB-1], x_reg} - {fit_reg[SB-1], fit_reg};
    assign resid_sat = (diff[SB] != diff[SB-1]) ?
                       (diff[SB] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}}) :
                       diff[SB-1:0];
    assign seasons_cur = series_start ? '0 : seasons_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= swfa_pkg::ST_IDLE;
            period_reg    <= swfa_pkg::PERIOD_BITS'(1);
            window_reg    <= swfa_pkg::WINDOW_BITS'(1);
            wpos_reg      <= '0;
            phase_reg     <= '0;
            seasons_reg   <= '0;
            rcnt_reg      <= '0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            period_reg    <= period_next;
            window_reg    <= window_next;
            wpos_reg      <= wpos_next;
            phase_reg     <= phase_next;
            seasons_reg   <= seasons_next;
            rcnt_reg      <= rcnt_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg      <= k_next;
        back_reg   <= back_next;
        sum_reg    <= sum_next;
        x_reg      <= x_next;
        fit_reg    <= fit_next;
        hist_reg   <= hist_next;
        fitted_reg <= fitted_next;
        resid_reg  <= resid_next;
        ohist_reg  <= ohist_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        period_next    = period_reg;
        window_next    = window_reg;
        wpos_next      = wpos_reg;
        phase_next     = phase_reg;
        seasons_next   = seasons_reg;
        k_next         = k_reg;
        rcnt_next      = rcnt_reg;
        back_next      = back_reg;
        sum_next       = sum_reg;
        x_next         = x_reg;
        fit_next       = fit_reg;
        hist_next      = hist_reg;
        fin_next       = fin_reg;
        out_valid_next = out_valid_reg;
        fitted_next    = fitted_reg;
        resid_next     = resid_reg;
        ohist_next     = ohist_reg;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        div_start      = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            case (cfg_index)
                swfa_pkg::REG_SEASON_LENGTH:
                begin
                    period_next  = cfg_data;
                    wpos_next    = '0;
                    phase_next   = '0;
                    seasons_next = '0;
                end
                swfa_pkg::REG_WINDOW_LENGTH:
                begin
                    window_next  = cfg_data[swfa_pkg::WINDOW_BITS-1:0];
                    wpos_next    = '0;
                    phase_next   = '0;
                    seasons_next = '0;
                end
                default:
                begin
                end
            endcase
        end

        case (state_reg)
            swfa_pkg::ST_IDLE:
            begin
                // finish a word: write the ring, advance position, phase and season count, load result
                if (fin_reg && out_free)
                begin
                    wr_en          = 1'b1;
                    fin_next       = 1'b0;
                    out_valid_next = 1'b1;
                    fitted_next    = fit_reg;
                    resid_next     = hist_reg ? resid_sat : '0;
                    ohist_next     = hist_reg;
                    wpos_next      = wpos_reg + 1'b1;
                    if (phase_inc >= p_eff)
                    begin
                        phase_next = '0;
                        seasons_next = (seasons_reg < w_eff) ? seasons_reg + 1'b1 : w_eff;
                    end
                    else
                    begin
                        phase_next = phase_inc[swfa_pkg::PHASE_BITS-1:0];
                    end
                end
                else if (in_take)
                begin
                    x_next = sample;
                    if (series_start)
                    begin
                        wpos_next    = '0;
                        phase_next   = '0;
                        seasons_next = '0;
                    end
                    if (seasons_cur == '0)
                    begin
                        fit_next  = sample;
                        hist_next = 1'b0;
                        fin_next  = 1'b1;
                    end
                    else
                    begin
                        hist_next  = 1'b1;
                        k_next     = (seasons_cur < w_eff) ? seasons_cur : w_eff;
                        rcnt_next  = '0;
                        back_next  = swfa_pkg::BACK_BITS'(p_eff);
                        sum_next   = '0;
                        state_next = swfa_pkg::ST_READ;
                    end
                end
            end
            swfa_pkg::ST_READ:
            begin
                if (rcnt_reg < k_reg)
                begin
                    rd_en     = 1'b1;
                    back_next = back_reg + swfa_pkg::BACK_BITS'(p_eff);
                end
                if (rcnt_reg != '0)
                begin
                    sum_next = sum_reg + swfa_pkg::SUM_BITS'(signed'(rd_data));
                end
                if (rcnt_reg == k_reg)
                begin
                    state_next = swfa_pkg::ST_DIVGO;
                end
                else
                begin
                    rcnt_next = rcnt_reg + 1'b1;
                end
            end
            swfa_pkg::ST_DIVGO:
            begin
                div_start  = 1'b1;
                state_next = swfa_pkg::ST_DIV;
            end
            swfa_pkg::ST_DIV:
            begin
                if (div_res.done)
                begin
                    fit_next   = div_res.quot;
                    fin_next   = 1'b1;
                    state_next = swfa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swfa_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign fitted       = fitted_reg;
    assign residual     = resid_reg;
    assign from_history = ohist_reg;

    a_first_season_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !from_history |-> residual == '0)
        else $error("first-season result with nonzero residual");

    a_read_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == swfa_pkg::ST_READ |-> rcnt_reg <= k_reg)
        else $error("history read count passed the window");

    a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
        div_res.busy |-> state_reg == swfa_pkg::ST_DIV)
        else $error("divider busy outside the divide step");

    a_seasons_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seasons_reg <= w_eff)
        else $error("season count above the window");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(fitted) && $stable(residual))
        else $error("result changed while stalled");

endmodule

// ===== tb/swfa_fit_checker.sv =====
// Checker for the seasonal window-average fit: watches the input, output and register ports,
// predicts each fitted word and compares it field by field. Depends on swfa_pkg.
module swfa_fit_checker
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    input  logic                                    in_stall,
    input  logic signed [swfa_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                                    series_start,
    input  logic                                    out_valid,
    input  logic                                    out_stall,
    input  logic signed [swfa_pkg::SAMPLE_BITS-1:0] fitted,
    input  logic signed [swfa_pkg::SAMPLE_BITS-1:0] residual,
    input  logic                                    from_history,
    input  logic                                    cfg_we,
    input  logic [swfa_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [swfa_pkg::CFG_BITS-1:0]           cfg_data,
    output int                                      errors,
    output int                                      pending,
    output int                                      checked,
    output int                                      from_past,
    output int                                      saturated
);

    localparam int SB = swfa_pkg::SAMPLE_BITS;

    typedef struct packed {
        logic signed [SB-1:0] fitted;
        logic signed [SB-1:0] residual;
        logic                 from_history;
    } fit_word_t;

    fit_word_t                               expected_fits[$];
    logic signed [SB-1:0]                    past_samples[swfa_pkg::RING_DEPTH];
    logic [swfa_pkg::ADDR_BITS-1:0]          ring_pos;
    int                                      phase_pos;
    int                                      seasons_done;
    logic [swfa_pkg::PERIOD_BITS-1:0]        period_reg;
    logic [swfa_pkg::WINDOW_BITS-1:0]        window_reg;
    fit_word_t                               got_word;
    fit_word_t                               want_word;

    task automatic report(input string what, input logic [SB-1:0] got, input logic [SB-1:0] want);
        $display("swfa check: word %0d %s got %h want %h", checked, what, got, want);
        errors++;
    endtask

    function automatic void restart_series();
        ring_pos = '0;
        phase_pos = 0;
        seasons_done = 0;
    endfunction

    function automatic fit_word_t fit_sample(input logic signed [SB-1:0] x, input logic start);
        fit_word_t                      w;
        int                             p;
        int                             win;
        int                             k;
        longint                         sum;
        longint                         fit;
        longint                         diff;
        longint                         hi;
        longint                         lo;
        logic [swfa_pkg::ADDR_BITS-1:0] slot;
        p = (period_reg == 0) ? 1 : (period_reg > swfa_pkg::MAX_PERIOD)
            ? swfa_pkg::MAX_PERIOD : int'(period_reg);
        win = (window_reg == 0) ? 1 : (window_reg > swfa_pkg::MAX_WINDOW)
            ? swfa_pkg::MAX_WINDOW : int'(window_reg);
        hi = (longint'(1) <<< (SB - 1)) - 1;
        lo = -hi - 1;
        if (start)
            restart_series();
        if (seasons_done == 0)
        begin
            w.fitted = x;
            w.residual = '0;
            w.from_history = 1'b0;
        end
        else
        begin
            k = (seasons_done < win) ? seasons_done : win;
            sum = 0;
            for (int i = 1; i <= k; i++)
            begin
                slot = ring_pos - swfa_pkg::ADDR_BITS'(p * i);
                sum += longint'(past_samples[slot]);
            end
            fit = sum / k;
            diff = longint'(x) - fit;
            if (diff > hi || diff < lo)
                saturated++;
            w.fitted = fit[SB-1:0];
            w.residual = (diff > hi) ? hi[SB-1:0] : (diff < lo) ? lo[SB-1:0] : diff[SB-1:0];
            w.from_history = 1'b1;
            from_past++;
        end
        past_samples[ring_pos] = x;
        ring_pos = ring_pos + 1'b1;
        phase_pos++;
        if (phase_pos >= p)
        begin
            phase_pos = 0;
            seasons_done = (seasons_done < win) ? seasons_done + 1 : win;
        end
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_fits.delete();
            restart_series();
            period_reg = swfa_pkg::PERIOD_BITS'(1);
            window_reg = swfa_pkg::WINDOW_BITS'(1);
            errors = 0;
            pending <= 0;
            checked = 0;
            from_past = 0;
            saturated = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == swfa_pkg::REG_SEASON_LENGTH)
                begin
                    period_reg = cfg_data[swfa_pkg::PERIOD_BITS-1:0];
                    restart_series();
                end
                else if (cfg_index == swfa_pkg::REG_WINDOW_LENGTH)
                begin
                    window_reg = cfg_data[swfa_pkg::WINDOW_BITS-1:0];
                    restart_series();
                end
            end
            if (in_valid && !in_stall)
                expected_fits.insert(expected_fits.size(), fit_sample(sample, series_start));
            if (out_valid && !out_stall)
            begin
                got_word.fitted = fitted;
                got_word.residual = residual;
                got_word.from_history = from_history;
                if (expected_fits.size() == 0)
                    report("arrived with nothing expected, fitted", got_word.fitted, '0);
                else
                begin
                    want_word = expected_fits.pop_front();
                    if (got_word.fitted !== want_word.fitted)
                        report("fitted", got_word.fitted, want_word.fitted);
                    if (got_word.residual !== want_word.residual)
                        report("residual", got_word.residual, want_word.residual);
                    if (got_word.from_history !== want_word.from_history)
                        report("from_history", {31'b0, got_word.from_history},
                               {31'b0, want_word.from_history});
                end
                checked++;
            end
            pending <= expected_fits.size();
        end
    end

endmodule

// ===== tb/seasonal_window_average_fit_tb.sv =====
// Testbench top for the seasonal window-average fit: clock, reset, register writes and sample
// words with random idling on both sides. Depends on swfa_pkg, swfa_fit_checker and the block.
module seasonal_window_average_fit_tb;

    localparam int SB = swfa_pkg::SAMPLE_BITS;
    localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};
    localparam int PHASES = 10;
    localparam int TOTAL_WORDS = 1770;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               in_valid = 1'b0;
    logic                               in_stall;
    logic signed [SB-1:0]               sample = '0;
    logic                               series_start = 1'b0;
    logic                               out_valid;
    logic                               out_stall = 1'b0;
    logic signed [SB-1:0]               fitted;
    logic signed [SB-1:0]               residual;
    logic                               from_history;
    logic                               cfg_we = 1'b0;
    logic [swfa_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [swfa_pkg::CFG_BITS-1:0]      cfg_data = '0;

    int errors;
    int pending;
    int checked;
    int from_past;
    int saturated;
    int words_sent = 0;
    int settings = 0;
    int tx_idle_pct = 29;
    int rx_stall_pct = 71;

    int unsigned periods[PHASES] = '{0, 3, 64, 5, 127, 2, 13, 1, 64, 7};
    int unsigned windows[PHASES] = '{0, 8, 8, 15, 1, 3, 2, 8, 0, 5};
    int unsigned lengths[PHASES] = '{60, 150, 600, 120, 150, 100, 150, 120, 150, 150};

    seasonal_window_average_fit dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .sample(sample),
        .series_start(series_start),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .fitted(fitted),
        .residual(residual),
        .from_history(from_history),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    swfa_fit_checker fit_check
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .sample(sample),
        .series_start(series_start),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .fitted(fitted),
        .residual(residual),
        .from_history(from_history),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .errors(errors),
        .pending(pending),
        .checked(checked),
        .from_past(from_past),
        .saturated(saturated)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
        out_stall <= (rx_stall_pct != 0) && ($urandom_range(99) < rx_stall_pct);

    task automatic send_word(input logic signed [SB-1:0] value, input logic start);
        if (words_sent < TOTAL_WORDS / 3)
        begin
            tx_idle_pct = 29;
            rx_stall_pct = 71;
        end
        else if (words_sent < 2 * TOTAL_WORDS / 3)
        begin
            tx_idle_pct = 71;
            rx_stall_pct = 29;
        end
        else
        begin
            tx_idle_pct = 0;
            rx_stall_pct = 0;
        end
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample <= value;
        series_start <= start;
        do
            @(posedge clk);
        while (in_stall);
        words_sent++;
    endtask

    // hold the sender until every fitted word is back, then let the block settle
    task automatic drain_fits();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_reg(input logic [swfa_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [swfa_pkg::CFG_BITS-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [SB-1:0] pick_sample();
        logic signed [SB-1:0] v;
        case ($urandom_range(9))
            0: v = S_MAX;
            1: v = S_MIN;
            2: v = $signed($urandom_range(200)) - 100;
            3: v = S_MAX - $urandom_range(1000);
            4: v = S_MIN + $urandom_range(1000);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting: period 1, window 1
        send_word(S_MAX, 1'b1);
        send_word(S_MIN, 1'b0);
        send_word(S_MAX, 1'b0);
        send_word('0, 1'b0);
        send_word(-1, 1'b0);
        send_word(1, 1'b0);
        send_word(32'sh0001_8000, 1'b0);
        send_word(-5, 1'b1);
        send_word(3, 1'b0);

        // window of three: negative sums truncate toward zero
        drain_fits();
        write_reg(swfa_pkg::REG_WINDOW_LENGTH, 7'd3);
        settings++;
        send_word(-1, 1'b0);
        send_word(-1, 1'b0);
        send_word('0, 1'b0);
        send_word(7, 1'b0);
        send_word(5, 1'b0);
        send_word(S_MIN, 1'b0);
        send_word(S_MIN, 1'b0);
        send_word(S_MIN, 1'b0);
        send_word(S_MAX, 1'b0);
        send_word(-9, 1'b1);
        send_word(S_MAX, 1'b0);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_fits();
            if (ph % 2 == 0)
            begin
                write_reg(swfa_pkg::REG_SEASON_LENGTH, periods[ph][6:0]);
                write_reg(swfa_pkg::REG_WINDOW_LENGTH,
                          {3'($urandom_range(7)), windows[ph][3:0]});
            end
            else
            begin
                write_reg(swfa_pkg::REG_WINDOW_LENGTH,
                          {3'($urandom_range(7)), windows[ph][3:0]});
                write_reg(swfa_pkg::REG_SEASON_LENGTH, periods[ph][6:0]);
            end
            settings++;
            for (int n = 0; n < lengths[ph]; n++)
            begin
                if (n == 40)
                    drain_fits();
                send_word(pick_sample(), $urandom_range(59) == 0);
            end
        end

        drain_fits();
        $display("%0d sample words over %0d register settings, idling on each side then none",
                 words_sent, settings);
        $display("%0d fits checked, %0d from past seasons, %0d residuals saturated",
                 checked, from_past, saturated);
        if (errors == 0)
            $display("seasonal_window_average_fit_tb: done, clean");
        else
            $display("seasonal_window_average_fit_tb: done, errors");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("seasonal_window_average_fit_tb: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/swfa_pkg.sv
rtl/swfa_hist.sv
rtl/swfa_div.sv
rtl/seasonal_window_average_fit.sv
tb/swfa_fit_checker.sv
tb/seasonal_window_average_fit_tb.sv
